[rtl/sdv_pkg.sv]
// ----------------------------------------------------------------------------
// sdv_pkg: shared types and constants of the digit-serial short divider
// Holds the request and result payloads, the sequencer state type, the
// control bundle that drives the shift-subtract unit, and fixed widths.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sdv_pkg;

  // Field widths fixed by the interface.
  localparam int DIGIT_W = 6;
  localparam int BASE_W  = 6;
  localparam int DIV_W   = 16;
  localparam int QUOT_W  = 7;
  localparam int COUNT_W = 16;

  // remainder * base + digit stays below 2**22.
  localparam int PART_W = DIV_W + BASE_W;

  // Quotient bits resolved per digit: seven when the held remainder is below
  // the divisor, the whole partial product otherwise.
  localparam int NARROW_STEPS = QUOT_W;
  localparam int WIDE_STEPS   = PART_W;
  localparam int STEP_CNT_W   = $clog2(WIDE_STEPS);

  localparam logic [QUOT_W-1:0]  QUOT_SAT  = '1;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Configuration register indexes.
  localparam logic REG_NUMBER_BASE   = 1'b0;
  localparam logic REG_DIVISOR_VALUE = 1'b1;

  localparam logic [BASE_W-1:0] BASE_RESET    = 6'd10;
  localparam logic [DIV_W-1:0]  DIVISOR_RESET = 16'd10;

  typedef struct packed {
    logic [DIGIT_W-1:0] digit_in;
    logic               last_digit;
  } sdv_in_t;

  typedef struct packed {
    logic [QUOT_W-1:0]  quotient_digit;
    logic [DIV_W-1:0]   remainder_now;
    logic [COUNT_W-1:0] leading_zeros;
    logic               end_of_number;
  } sdv_out_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_FIN
  } sdv_state_t;

  // Sequencer commands to the datapath.
  typedef struct packed {
    logic load;
    logic step;
    logic commit;
  } sdv_ctl_t;

endpackage

`default_nettype wire

[rtl/sdv_div_unit.sv]
// ----------------------------------------------------------------------------
// sdv_div_unit: shared restoring shift-subtract divider
// Resolves one quotient bit per step by shifting the next dividend bit into
// the partial remainder and subtracting the divisor when it fits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sdv_div_unit (
  input  wire logic                        clk,
  input  wire sdv_pkg::sdv_ctl_t           ctl,
  input  wire logic                        wide,
  input  wire logic [sdv_pkg::PART_W-1:0]  partial,
  input  wire logic [sdv_pkg::DIV_W-1:0]   divisor,
  output logic      [sdv_pkg::DIV_W-1:0]   rem,
  output logic      [sdv_pkg::PART_W-1:0]  quot
);
  import sdv_pkg::*;

  localparam int NARROW_HI = PART_W - NARROW_STEPS;

  logic [DIV_W-1:0]  acc;
  logic [PART_W-1:0] dividend;
  logic [PART_W-1:0] q;
  logic [DIV_W:0]    acc_sh;
  logic [DIV_W:0]    acc_sub;
  logic              fits;

  // One restoring step: shift in a dividend bit, subtract if it fits.
  always_comb begin
    acc_sh  = {acc, dividend[PART_W-1]};
    acc_sub = acc_sh - {1'b0, divisor};
    fits    = (acc_sh >= {1'b0, divisor});
  end

  // The narrow start preloads the upper bits, which are known to be below
  // the divisor, so only the low seven bits remain to be resolved.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      q <= '0;
      if (wide) begin
        acc      <= '0;
        dividend <= partial;
      end else begin
        acc      <= DIV_W'(partial[PART_W-1:NARROW_STEPS]);
        dividend <= {partial[NARROW_STEPS-1:0], {NARROW_HI{1'b0}}};
      end
    end else if (ctl.step) begin
      acc      <= fits ? acc_sub[DIV_W-1:0] : acc_sh[DIV_W-1:0];
      dividend <= {dividend[PART_W-2:0], 1'b0};
      q        <= {q[PART_W-2:0], fits};
    end
  end

  assign rem  = acc;
  assign quot = q;

endmodule

`default_nettype wire

[rtl/sdv_ctrl.sv]
// ----------------------------------------------------------------------------
// sdv_ctrl: sequencer of the short divider
// Takes a request, runs the shift-subtract unit for the needed number of
// steps and hands the result over once the output register is free.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sdv_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire logic              wide,
  input  wire logic              out_free,
  output logic                   in_ready,
  output sdv_pkg::sdv_ctl_t      ctl
);
  import sdv_pkg::*;

  sdv_state_t            state;
  sdv_state_t            state_next;
  logic [STEP_CNT_W-1:0] count;
  logic [STEP_CNT_W-1:0] count_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    count_next = count;
    in_ready   = 1'b0;
    ctl        = '0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.load   = 1'b1;
          count_next = wide ? STEP_CNT_W'(WIDE_STEPS - 1)
                            : STEP_CNT_W'(NARROW_STEPS - 1);
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        ctl.step = 1'b1;
        if (count == '0) begin
          state_next = S_FIN;
        end else begin
          count_next = count - 1'b1;
        end
      end
      S_FIN: begin
        if (out_free) begin
          ctl.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // The step counter never starts above the wide step count.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> count <= STEP_CNT_W'(WIDE_STEPS - 1))
    else $error("step counter out of range");

endmodule

`default_nettype wire

[rtl/digit_serial_short_divider.sv]
// ----------------------------------------------------------------------------
// digit_serial_short_divider: short division of a digit stream
// Divides a number given most significant digit first in a configurable
// base by a configured divisor, one quotient digit per request, with the
// running remainder and a saturating count of leading zero quotient digits.
//
//   Channel  Direction  Handshake            Payload
//   in       input      in_valid/in_ready    sdv_in_t  (digit_in, last_digit)
//   out      output     out_valid/out_ready  sdv_out_t (quotient, remainder,
//                                                       leading zeros, end)
//   cfg      input      cfg_write            cfg_index, cfg_data
//
// A request is taken and remainder * base + digit formed, then the
// shift-subtract unit runs seven steps and the result register is written.
// If the held remainder is not below the divisor (the divisor was rewritten
// mid-number) the unit runs 22 steps; the sequencer sets the step count.
// Reset is synchronous; it restores base 10, divisor 10 and a cleared number.
// A stalled output holds the finished result; the next request is taken
// while it waits, and its result waits in turn until the register frees.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module digit_serial_short_divider (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire sdv_pkg::sdv_in_t           in_data,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output sdv_pkg::sdv_out_t               out_data,
  input  wire logic                       cfg_write,
  input  wire logic                       cfg_index,
  input  wire logic [sdv_pkg::DIV_W-1:0]  cfg_data
);
  import sdv_pkg::*;

  logic [BASE_W-1:0]  number_base;
  logic [DIV_W-1:0]   divisor_value;
  logic [DIV_W-1:0]   running_remainder;
  logic [COUNT_W-1:0] zero_run_count;
  logic               still_leading;
  logic               last_held;

  sdv_ctl_t           ctl;
  logic               wide;
  logic               out_free;
  logic [PART_W-1:0]  partial;
  logic [DIV_W-1:0]   unit_rem;
  logic [PART_W-1:0]  unit_quot;

  logic [QUOT_W-1:0]  quot_res;
  logic [DIV_W-1:0]   rem_res;
  logic [COUNT_W-1:0] count_next;
  logic               leading_next;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      number_base   <= BASE_RESET;
      divisor_value <= DIVISOR_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_NUMBER_BASE:   number_base   <= cfg_data[BASE_W-1:0];
        REG_DIVISOR_VALUE: divisor_value <= cfg_data;
        default: ;
      endcase
    end
  end

  // Partial dividend for the incoming digit.
  always_comb begin
    partial = PART_W'({{BASE_W{1'b0}}, running_remainder} *
                      {{DIV_W{1'b0}}, number_base})
            + PART_W'(in_data.digit_in);
    wide    = (running_remainder >= divisor_value);
  end

  assign out_free = !out_valid || out_ready;

  sdv_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .wide     (wide),
    .out_free (out_free),
    .in_ready (in_ready),
    .ctl      (ctl)
  );

  sdv_div_unit u_div (
    .clk     (clk),
    .ctl     (ctl),
    .wide    (wide),
    .partial (partial),
    .divisor (divisor_value),
    .rem     (unit_rem),
    .quot    (unit_quot)
  );

  // Saturate the quotient and apply the zero-divisor rule.
  always_comb begin
    if (divisor_value == '0) begin
      quot_res = QUOT_SAT;
      rem_res  = '0;
    end else begin
      quot_res = (|unit_quot[PART_W-1:QUOT_W]) ? QUOT_SAT : unit_quot[QUOT_W-1:0];
      rem_res  = unit_rem;
    end
    count_next   = zero_run_count;
    leading_next = still_leading;
    if (still_leading) begin
      if (quot_res == '0) begin
        if (zero_run_count != COUNT_MAX) begin
          count_next = zero_run_count + 1'b1;
        end
      end else begin
        leading_next = 1'b0;
      end
    end
  end

  // Number state; a last digit clears it for the next number.
  always_ff @(posedge clk) begin
    if (rst) begin
      running_remainder <= '0;
      zero_run_count    <= '0;
      still_leading     <= 1'b1;
    end else if (ctl.commit) begin
      if (last_held) begin
        running_remainder <= '0;
        zero_run_count    <= '0;
        still_leading     <= 1'b1;
      end else begin
        running_remainder <= rem_res;
        zero_run_count    <= count_next;
        still_leading     <= leading_next;
      end
    end
  end

  // The end marker travels with the request.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      last_held <= in_data.last_digit;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      out_data.quotient_digit <= quot_res;
      out_data.remainder_now  <= rem_res;
      out_data.leading_zeros  <= count_next;
      out_data.end_of_number  <= last_held;
    end
  end

  // A result is written only into a free output register.
  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    ctl.commit |-> (!out_valid || out_ready))
    else $error("result written over a pending one");

  // The held remainder stays below the divisor it was formed with.
  a_rem_below: assert property (@(posedge clk) disable iff (rst)
    ($past(ctl.commit) && $past(divisor_value) != '0)
      |-> running_remainder < $past(divisor_value))
    else $error("held remainder not below divisor");

  // The leading run ends only when a result is written.
  a_leading_fall: assert property (@(posedge clk) disable iff (rst)
    $fell(still_leading) |-> $past(ctl.commit))
    else $error("leading flag dropped outside a result write");

endmodule

`default_nettype wire

[tb/sdv_result_monitor.sv]
// ----------------------------------------------------------------------------
// sdv_result_monitor: result prediction and comparison for the short divider
// Watches the register port and the request and result channels of the divider,
// predicts each quotient digit, remainder and leading-zero count, and
// compares every accepted result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sdv_result_monitor (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  input  wire logic                       in_ready,
  input  wire sdv_pkg::sdv_in_t           in_data,
  input  wire logic                       out_valid,
  input  wire logic                       out_ready,
  input  wire sdv_pkg::sdv_out_t          out_data,
  input  wire logic                       cfg_write,
  input  wire logic                       cfg_index,
  input  wire logic [sdv_pkg::DIV_W-1:0]  cfg_data,
  output int                              mismatch_count,
  output int                              results_owed
);
  import sdv_pkg::*;

  // Shadow copy of the registers and of the per-number state.
  logic [BASE_W-1:0]  base_reg;
  logic [DIV_W-1:0]   divisor_reg;
  logic [DIV_W-1:0]   carry_rem;
  logic [COUNT_W-1:0] zero_run;
  logic               in_lead;

  sdv_out_t owed_q[$];
  int       errors = 0;

  // One digit of short division: remainder * base + digit over the divisor.
  function automatic sdv_out_t divide_digit(input sdv_in_t req);
    int unsigned partial;
    int unsigned quot;
    int unsigned rem;
    sdv_out_t    res;
    partial = carry_rem * base_reg + req.digit_in;
    if (divisor_reg == '0) begin
      quot = QUOT_SAT;
      rem  = 0;
    end else begin
      quot = partial / divisor_reg;
      rem  = partial % divisor_reg;
      if (quot > QUOT_SAT) begin
        quot = QUOT_SAT;
      end
    end
    carry_rem = rem[DIV_W-1:0];
    // The zero count only grows while no nonzero quotient digit has shown up.
    if (in_lead) begin
      if (quot == 0) begin
        if (zero_run != COUNT_MAX) begin
          zero_run = zero_run + 1'b1;
        end
      end else begin
        in_lead = 1'b0;
      end
    end
    res.quotient_digit = quot[QUOT_W-1:0];
    res.remainder_now  = carry_rem;
    res.leading_zeros  = zero_run;
    res.end_of_number  = req.last_digit;
    if (req.last_digit) begin
      carry_rem = '0;
      zero_run  = '0;
      in_lead   = 1'b1;
    end
    return res;
  endfunction

  // Track registers and requests, then check each accepted result.
  always @(posedge clk) begin
    sdv_out_t got;
    sdv_out_t want;
    logic     bad;
    if (rst) begin
      base_reg    = BASE_RESET;
      divisor_reg = DIVISOR_RESET;
      carry_rem   = '0;
      zero_run    = '0;
      in_lead     = 1'b1;
      owed_q.delete();
    end else begin
      if (cfg_write) begin
        if (cfg_index == REG_NUMBER_BASE) begin
          base_reg = cfg_data[BASE_W-1:0];
        end else begin
          divisor_reg = cfg_data;
        end
      end
      if (in_valid && in_ready) begin
        owed_q.push_back(divide_digit(in_data));
      end
      if (out_valid && out_ready) begin
        got = out_data;
        if (owed_q.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("[%0t] result with nothing predicted: q %0d rem %0d zeros %0d end %0b",
                     $time, got.quotient_digit, got.remainder_now,
                     got.leading_zeros, got.end_of_number);
          end
        end else begin
          want = owed_q.pop_front();
          bad = (got.quotient_digit !== want.quotient_digit) ||
                (got.remainder_now  !== want.remainder_now)  ||
                (got.leading_zeros  !== want.leading_zeros)  ||
                (got.end_of_number  !== want.end_of_number);
          if (bad) begin
            errors++;
            if (errors <= 10) begin
              $display("[%0t] result differs (expected/actual): q %0d/%0d rem %0d/%0d",
                       $time, want.quotient_digit, got.quotient_digit,
                       want.remainder_now, got.remainder_now);
              $display("    zeros %0d/%0d end %0b/%0b", want.leading_zeros,
                       got.leading_zeros, want.end_of_number, got.end_of_number);
            end
          end
        end
      end
    end
    results_owed   <= owed_q.size();
    mismatch_count <= errors;
  end

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the digit-serial short divider
// Feeds directed and random digit streams under changing base and divisor
// settings, with random gaps and output stalls, and a long run of zero
// quotient digits that keeps the leading-zero count climbing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import sdv_pkg::*;

  logic               clk;
  logic               rst       = 1'b1;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  sdv_in_t            in_data   = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  sdv_out_t           out_data;
  logic               cfg_write = 1'b0;
  logic               cfg_index = REG_NUMBER_BASE;
  logic [DIV_W-1:0]   cfg_data  = '0;

  int mismatch_count;
  int results_owed;

  // Gap rates in percent for the request and result sides.
  int send_idle_pct = 21;
  int recv_idle_pct = 48;

  int cur_base      = 10;
  int digits_sent   = 0;
  int numbers_done  = 0;
  int settings_used = 0;

  digit_serial_short_divider DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  sdv_result_monitor monitor (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .results_owed   (results_owed)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Result side stalls at random.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Present one digit request and hold it until it is taken.
  task automatic push_digit(input logic [DIGIT_W-1:0] digit, input logic last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{digit_in: digit, last_digit: last};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    digits_sent++;
    if (last) begin
      numbers_done++;
    end
  endtask

  // Stop sending and wait until every predicted result has come out.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
  endtask

  // Write both registers; the base word may carry junk above bit 5.
  task automatic set_config(input logic [DIV_W-1:0] base_word,
                            input logic [DIV_W-1:0] div_word);
    cfg_write <= 1'b1;
    cfg_index <= REG_NUMBER_BASE;
    cfg_data  <= base_word;
    @(posedge clk);
    cfg_index <= REG_DIVISOR_VALUE;
    cfg_data  <= div_word;
    @(posedge clk);
    cfg_write <= 1'b0;
    cur_base = base_word[BASE_W-1:0];
    settings_used++;
  endtask

  // Pick a setting, mostly a legal base, now and then a degenerate one.
  task automatic random_config();
    logic [DIV_W-1:0] base_word;
    logic [DIV_W-1:0] div_word;
    int               b;
    case ($urandom_range(0, 9))
      0:       b = $urandom_range(0, 1);
      1:       b = $urandom_range(37, 63);
      default: b = $urandom_range(2, 36);
    endcase
    base_word = DIV_W'(($urandom_range(0, 1023) << BASE_W) | b);
    case ($urandom_range(0, 9))
      0:       div_word = '0;
      1, 2:    div_word = DIV_W'($urandom_range(1, 65535));
      3, 4:    div_word = DIV_W'($urandom_range(1, 255));
      default: div_word = DIV_W'($urandom_range(1, 16));
    endcase
    set_config(base_word, div_word);
  endtask

  // Random numbers; some are cut short and get a new setting mid-number.
  task automatic random_numbers(input int item_goal);
    int                 sent;
    int                 len;
    logic               broken;
    logic [DIGIT_W-1:0] digit;
    sent = 0;
    while (sent < item_goal) begin
      if ($urandom_range(0, 5) == 0) begin
        drain();
        random_config();
      end
      len    = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
      broken = ($urandom_range(0, 7) == 0);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 9) == 0 || cur_base < 2) begin
          digit = DIGIT_W'($urandom_range(0, 63));
        end else begin
          digit = DIGIT_W'($urandom_range(0, cur_base - 1));
        end
        push_digit(digit, (i == len - 1) && !broken);
        sent++;
      end
      if (broken) begin
        drain();
        random_config();
      end
    end
  endtask

  initial begin
    int waited;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Reset setting: leading zeros, then a digit far above the base.
    push_digit(6'd0, 1'b0);
    push_digit(6'd0, 1'b0);
    push_digit(6'd7, 1'b0);
    push_digit(6'd3, 1'b1);
    push_digit(6'd63, 1'b1);

    // Smallest legal base with divisor one.
    drain();
    set_config(16'd2, 16'd1);
    push_digit(6'd1, 1'b0);
    push_digit(6'd0, 1'b0);
    push_digit(6'd1, 1'b1);

    // Largest base and divisor, remainder built up and held over.
    drain();
    set_config(16'hFFE4, 16'hFFFF);
    push_digit(6'd35, 1'b0);
    push_digit(6'd35, 1'b0);
    push_digit(6'd35, 1'b0);

    // Divisor dropped mid-number: the held remainder overflows the quotient.
    drain();
    set_config(16'd63, 16'd1);
    push_digit(6'd63, 1'b1);

    // Base zero with a zero divisor.
    drain();
    set_config(16'hFFC0, 16'd0);
    push_digit(6'd5, 1'b0);
    push_digit(6'd0, 1'b1);

    // Base one just sums the digits.
    drain();
    set_config(16'hFFC1, 16'd7);
    repeat (3) push_digit(6'd6, 1'b0);
    push_digit(6'd6, 1'b1);

    // Wide divisor gives a long leading run.
    drain();
    set_config(16'd36, 16'hFFFF);
    push_digit(6'd0, 1'b0);
    push_digit(6'd35, 1'b0);
    push_digit(6'd35, 1'b1);

    drain();
    set_config(16'd10, 16'd10);
    random_numbers(270);

    drain();
    send_idle_pct = 48;
    recv_idle_pct = 21;
    random_numbers(270);

    drain();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_numbers(280);

    // A long run of zero quotient digits in one number.
    drain();
    set_config(16'd2, 16'd3);
    repeat (30) push_digit(6'd0, 1'b0);
    push_digit(6'd1, 1'b0);
    push_digit(6'd1, 1'b1);

    // Let the last results out, within a bound.
    in_valid <= 1'b0;
    waited = 0;
    while (results_owed != 0 && waited < 200000) begin
      @(posedge clk);
      waited++;
    end
    repeat (40) @(posedge clk);

    $display("Run covered %0d digits in %0d numbers over %0d register settings.",
             digits_sent, numbers_done, settings_used);
    $display("Idle mixes 21/48, 48/21 and none; a long leading zero run included.");
    if (mismatch_count == 0 && results_owed == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Hard stop far beyond the slowest correct run.
  initial begin
    #80000000;
    $display("Mismatches found");
    $finish;
  end

endmodule

[files.f]
rtl/sdv_pkg.sv
rtl/sdv_div_unit.sv
rtl/sdv_ctrl.sv
rtl/digit_serial_short_divider.sv
tb/sdv_result_monitor.sv
tb/tb_top.sv
